[design/mp2d_pkg.sv]
package mp2d_pkg;

	localparam int DEF_MAX_PLANE_WIDTH = 1024;
	localparam int DEF_MAX_WINDOW      = 8;
	localparam int DEF_SAMPLE_BITS     = 16;

	localparam int PLANE_CFG_BITS = 11;
	localparam int WIN_CFG_BITS   = 4;
	localparam int CFG_DATA_BITS  = 11;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PLANE_WIDTH   = 3'd0,
		REG_PLANE_HEIGHT  = 3'd1,
		REG_WINDOW_WIDTH  = 3'd2,
		REG_WINDOW_HEIGHT = 3'd3,
		REG_STRIDE_X      = 3'd4,
		REG_STRIDE_Y      = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [PLANE_CFG_BITS-1:0] plane_width;
		logic [PLANE_CFG_BITS-1:0] plane_height;
		logic [WIN_CFG_BITS-1:0]   window_width;
		logic [WIN_CFG_BITS-1:0]   window_height;
		logic [WIN_CFG_BITS-1:0]   stride_x;
		logic [WIN_CFG_BITS-1:0]   stride_y;
	} cfg_regs_t;

	localparam cfg_regs_t CFG_RESET = '{
		plane_width:   11'd64,
		plane_height:  11'd64,
		window_width:  4'd2,
		window_height: 4'd2,
		stride_x:      4'd2,
		stride_y:      4'd2
	};

endpackage

[design/mp2d_stream_if.sv]
interface mp2d_sample_if #(
	parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface mp2d_pool_if #(
	parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] pooled_value;
	logic                          end_of_row;
	logic                          end_of_frame;

	modport source (output valid, output pooled_value, output end_of_row, output end_of_frame,
		input ready);
	modport sink   (input valid, input pooled_value, input end_of_row, input end_of_frame,
		output ready);
endinterface

[design/mp2d_ram.sv]
module mp2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[design/mp2d_cfg_regs.sv]
module mp2d_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [mp2d_pkg::CFG_INDEX_BITS-1:0] index,
	input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]  data,
	output mp2d_pkg::cfg_regs_t                 regs,
	output logic                                restart
);
	import mp2d_pkg::*;

	cfg_regs_t regs_q;
	logic      known;

	always_comb begin
		unique case (reg_index_t'(index))
			REG_PLANE_WIDTH, REG_PLANE_HEIGHT, REG_WINDOW_WIDTH,
			REG_WINDOW_HEIGHT, REG_STRIDE_X, REG_STRIDE_Y: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (we) begin
			unique case (reg_index_t'(index))
				REG_PLANE_WIDTH:   regs_q.plane_width   <= data[PLANE_CFG_BITS-1:0];
				REG_PLANE_HEIGHT:  regs_q.plane_height  <= data[PLANE_CFG_BITS-1:0];
				REG_WINDOW_WIDTH:  regs_q.window_width  <= data[WIN_CFG_BITS-1:0];
				REG_WINDOW_HEIGHT: regs_q.window_height <= data[WIN_CFG_BITS-1:0];
				REG_STRIDE_X:      regs_q.stride_x      <= data[WIN_CFG_BITS-1:0];
				REG_STRIDE_Y:      regs_q.stride_y      <= data[WIN_CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign regs    = regs_q;
	// any known register write starts a new plane
	assign restart = we && known;
endmodule

[design/max_pool_2d_stream_core.sv]
// Streaming 2-D max pooling.
// samples: one signed sample per beat, planes in raster order, back to back.
// results: one beat per completed window, carrying the window maximum and
//   end_of_row / end_of_frame marks for the last window of an output row / plane.
// cfg_we/cfg_index/cfg_data: register writes, to be made by the user only while idle;
//   not enforced by the block; a known register write restarts the plane at row 0, column 0.
// Throughput: one sample per cycle while not stalled. The horizontal max over the last
//   window_width samples runs in stage 1, the vertical max over the line RAMs (one per
//   row slot, read at the sample's column) in stage 2, and the result register follows.
// The beat that closes a window passes stage 1 and stage 2; its result is then registered.
// Reset: registers return to 64x64 plane, 2x2 window, stride 2; counters clear.
//   The line RAMs are not cleared; a window only reads rows of the current plane.
// Stall: the result register holds while results.ready is low; stages behind it
//   keep moving as long as they carry no result, then samples.ready drops.
module max_pool_2d_stream_core #(
	parameter int MAX_PLANE_WIDTH = mp2d_pkg::DEF_MAX_PLANE_WIDTH,
	parameter int MAX_WINDOW      = mp2d_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS     = mp2d_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mp2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	mp2d_sample_if.sink                         samples,
	mp2d_pool_if.source                         results
);
	import mp2d_pkg::*;

	localparam int CW        = $clog2(MAX_PLANE_WIDTH);
	localparam int DW        = CW + 1;
	localparam int NW        = DW + 1;
	localparam int KW        = $clog2(MAX_WINDOW + 1);
	localparam int SW        = $clog2(MAX_WINDOW);
	localparam int AGE_BITS  = SW + 1;

	cfg_regs_t regs;
	logic      restart;

	mp2d_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (cfg_we),
		.index   (cfg_index),
		.data    (cfg_data),
		.regs    (regs),
		.restart (restart)
	);

	// effective sizes
	logic [DW-1:0]           pw, ph;
	logic [KW-1:0]           ww, wh;
	logic [WIN_CFG_BITS-1:0] sx, sy;

	always_comb begin
		if (regs.plane_width == '0) pw = DW'(1);
		else if (32'(regs.plane_width) > MAX_PLANE_WIDTH) pw = DW'(MAX_PLANE_WIDTH);
		else pw = DW'(regs.plane_width);
		if (regs.plane_height == '0) ph = DW'(1);
		else if (32'(regs.plane_height) > MAX_PLANE_WIDTH) ph = DW'(MAX_PLANE_WIDTH);
		else ph = DW'(regs.plane_height);
		if (regs.window_width == '0) ww = KW'(1);
		else if (32'(regs.window_width) > MAX_WINDOW) ww = KW'(MAX_WINDOW);
		else ww = KW'(regs.window_width);
		if (regs.window_height == '0) wh = KW'(1);
		else if (32'(regs.window_height) > MAX_WINDOW) wh = KW'(MAX_WINDOW);
		else wh = KW'(regs.window_height);
		sx = (regs.stride_x == '0) ? WIN_CFG_BITS'(1) : regs.stride_x;
		sy = (regs.stride_y == '0) ? WIN_CFG_BITS'(1) : regs.stride_y;
	end

	// pipeline handshake
	logic valid_s1, valid_s2, out_valid_q;
	logic emit_s1, emit_s2;
	logic adv1, adv2, out_load, in_ready, in_fire;

	assign adv2     = valid_s2 && (!emit_s2 || !out_valid_q || results.ready);
	assign out_load = adv2 && emit_s2;
	assign adv1     = valid_s1 && (!valid_s2 || adv2);
	assign in_ready = !valid_s1 || adv1;
	assign in_fire  = samples.valid && in_ready;

	// position counters; next_x/next_y hold the column/row of the next window end
	logic [CW-1:0] col_q, row_q;
	logic [NW-1:0] next_x_q, next_y_q, nx, ny;
	logic [SW-1:0] slot_q;
	logic          hit_x, hit_y, last_col, last_row, eor, eof;

	always_comb begin
		nx       = (col_q == '0) ? NW'(ww) - NW'(1) : next_x_q;
		ny       = (row_q == '0) ? NW'(wh) - NW'(1) : next_y_q;
		hit_x    = NW'(col_q) == nx;
		hit_y    = NW'(row_q) == ny;
		last_col = {1'b0, col_q} + DW'(1) >= pw;
		last_row = {1'b0, row_q} + DW'(1) >= ph;
		eor      = NW'(col_q) + NW'(sx) >= NW'(pw);
		eof      = eor && (NW'(row_q) + NW'(sy) >= NW'(ph));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			next_x_q <= '0;
			next_y_q <= '0;
			slot_q   <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q    <= '0;
				next_y_q <= hit_y ? ny + NW'(sy) : ny;
				if (last_row) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + CW'(1);
					slot_q <= (32'(slot_q) == MAX_WINDOW - 1) ? '0 : slot_q + SW'(1);
				end
			end else begin
				col_q    <= col_q + CW'(1);
				next_x_q <= hit_x ? nx + NW'(sx) : nx;
			end
		end
	end

	// row taps: tap 0 is the newest sample
	logic signed [SAMPLE_BITS-1:0] taps_q [MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			taps_q[0] <= samples.sample;
			for (int k = 1; k < MAX_WINDOW; k++) begin
				taps_q[k] <= taps_q[k-1];
			end
		end
	end

	// stage 1
	logic [CW-1:0] col_s1;
	logic [SW-1:0] slot_s1;
	logic          eor_s1, eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1  <= col_q;
			slot_s1 <= slot_q;
			emit_s1 <= hit_x && hit_y;
			eor_s1  <= eor;
			eof_s1  <= eof;
		end
	end

	logic signed [SAMPLE_BITS-1:0] hmax;
	logic [MAX_WINDOW-1:0]         use_rows;

	always_comb begin
		hmax = taps_q[0];
		for (int k = 1; k < MAX_WINDOW; k++) begin
			if (k < 32'(ww) && taps_q[k] > hmax) hmax = taps_q[k];
		end
	end

	// slots of older rows that fall inside the window
	always_comb begin
		logic [AGE_BITS-1:0] age;
		for (int k = 0; k < MAX_WINDOW; k++) begin
			if (32'(slot_s1) >= k) age = AGE_BITS'(32'(slot_s1) - k);
			else age = AGE_BITS'(32'(slot_s1) + MAX_WINDOW - k);
			use_rows[k] = (age != '0) && (32'(age) < 32'(wh));
		end
	end

	// line RAMs: one row of horizontal maxima per slot; the own slot is written
	// while the others are read at the same column
	logic [SAMPLE_BITS-1:0] rd_data [MAX_WINDOW];

	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_line
		mp2d_ram #(
			.WIDTH (SAMPLE_BITS),
			.DEPTH (MAX_PLANE_WIDTH)
		) u_ram (
			.clk   (clk),
			.we    (adv1 && (32'(slot_s1) == g)),
			.waddr (col_s1),
			.wdata (hmax),
			.re    (adv1),
			.raddr (col_s1),
			.rdata (rd_data[g])
		);
	end

	// stage 2
	logic signed [SAMPLE_BITS-1:0] hmax_s2, vmax;
	logic [MAX_WINDOW-1:0]         use_s2;
	logic                          eor_s2, eof_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			hmax_s2 <= hmax;
			use_s2  <= use_rows;
			emit_s2 <= emit_s1;
			eor_s2  <= eor_s1;
			eof_s2  <= eof_s1;
		end
	end

	always_comb begin
		vmax = hmax_s2;
		for (int k = 0; k < MAX_WINDOW; k++) begin
			if (use_s2[k] && $signed(rd_data[k]) > vmax) vmax = $signed(rd_data[k]);
		end
	end

	// result register
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic                          out_eor_q, out_eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= vmax;
			out_eor_q   <= eor_s2;
			out_eof_q   <= eof_s2;
		end
	end

	assign samples.ready        = in_ready;
	assign results.valid        = out_valid_q;
	assign results.pooled_value = out_value_q;
	assign results.end_of_row   = out_eor_q;
	assign results.end_of_frame = out_eof_q;

	a_col_in_plane: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < pw)
		else $error("column counter beyond plane width");

	a_eof_has_eor: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (!results.end_of_frame || results.end_of_row))
		else $error("end of frame without end of row");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s2 && emit_s2))
		else $error("result without a completed window");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import mp2d_pkg::*;

	localparam int SAMPLE_W     = DEF_SAMPLE_BITS;
	localparam int MAXW         = DEF_MAX_WINDOW;
	localparam int MAXPW        = DEF_MAX_PLANE_WIDTH;
	localparam int STRIDE_LIMIT = (1 << WIN_CFG_BITS) - 1;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 500;
	localparam int PLANE_FEED   = 200;
	localparam int PRINT_LIMIT  = 40;

	// indexes outside the register map; a write there must change nothing
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                eor;
		logic                eof;
	} pool_beat_t;

	class pooled_value_tracker;
		logic [PLANE_CFG_BITS-1:0] plane_w, plane_h;
		logic [WIN_CFG_BITS-1:0]   win_w, win_h, step_x, step_y;
		int unsigned               col, row;
		logic signed [SAMPLE_W-1:0] lines [MAXW][MAXPW];
		pool_beat_t                pooled_due[$];
		int unsigned               n_pooled, n_row_ends, n_plane_ends;

		function new();
			plane_w = CFG_RESET.plane_width;
			plane_h = CFG_RESET.plane_height;
			win_w   = CFG_RESET.window_width;
			win_h   = CFG_RESET.window_height;
			step_x  = CFG_RESET.stride_x;
			step_y  = CFG_RESET.stride_y;
			col = 0;
			row = 0;
			n_pooled = 0;
			n_row_ends = 0;
			n_plane_ends = 0;
		endfunction

		static function int unsigned fit(int unsigned v, int unsigned hi);
			if (v == 0)
				return 1;
			return (v > hi) ? hi : v;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_PLANE_WIDTH:   plane_w = data;
				REG_PLANE_HEIGHT:  plane_h = data;
				REG_WINDOW_WIDTH:  win_w   = data[WIN_CFG_BITS-1:0];
				REG_WINDOW_HEIGHT: win_h   = data[WIN_CFG_BITS-1:0];
				REG_STRIDE_X:      step_x  = data[WIN_CFG_BITS-1:0];
				REG_STRIDE_Y:      step_y  = data[WIN_CFG_BITS-1:0];
				default:           return;
			endcase
			col = 0;
			row = 0;
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] s);
			int unsigned pw, ph, ww, wh, sx, sy, c, r, top, left;
			logic signed [SAMPLE_W-1:0] best;
			pool_beat_t b;
			pw = fit(plane_w, MAXPW);
			ph = fit(plane_h, MAXPW);
			ww = fit(win_w, MAXW);
			wh = fit(win_h, MAXW);
			sx = fit(step_x, STRIDE_LIMIT);
			sy = fit(step_y, STRIDE_LIMIT);
			c = (col >= pw) ? 0 : col;
			r = (row >= ph) ? 0 : row;
			lines[r % MAXW][c] = s;
			if (r + 1 >= wh && c + 1 >= ww &&
				(r + 1 - wh) % sy == 0 && (c + 1 - ww) % sx == 0) begin
				top  = r + 1 - wh;
				left = c + 1 - ww;
				best = lines[top % MAXW][left];
				for (int i = 0; i < wh; i++)
					for (int j = 0; j < ww; j++)
						if (lines[(top + i) % MAXW][left + j] > best)
							best = lines[(top + i) % MAXW][left + j];
				b.value = best;
				b.eor   = (c + sx >= pw);
				b.eof   = b.eor && (r + sy >= ph);
				pooled_due.push_back(b);
			end
			c++;
			if (c >= pw) begin
				c = 0;
				r++;
				if (r >= ph)
					r = 0;
			end
			col = c;
			row = r;
		endfunction

		// returns an empty string when the beat is the one due
		function string match_pooled(pool_beat_t got);
			pool_beat_t want;
			if (pooled_due.size() == 0)
				return $sformatf("unexpected pooled value %0d eor %b eof %b",
					$signed(got.value), got.eor, got.eof);
			want = pooled_due.pop_front();
			n_pooled++;
			if (want.eor)
				n_row_ends++;
			if (want.eof)
				n_plane_ends++;
			if (got.value !== want.value || got.eor !== want.eor || got.eof !== want.eof)
				return $sformatf("pooled beat %0d: got %0d eor %b eof %b, want %0d eor %b eof %b",
					n_pooled, $signed(got.value), got.eor, got.eof,
					$signed(want.value), want.eor, want.eof);
			return "";
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	mp2d_sample_if samples_ch ();
	mp2d_pool_if   pool_ch ();

	max_pool_2d_stream_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.results   (pool_ch)
	);

	pooled_value_tracker pooler;
	int errors    = 0;
	int n_sent    = 0;
	int n_configs = 0;
	int send_calm = 0;

	always #5 clk = ~clk;

	task automatic report(input string what);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t ns: ERROR %s", $time, what);
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int d;
		d = $urandom_range(0, 8);
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2:       return SAMPLE_W'(d - 4);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic int unsigned rand_reg_value(reg_index_t which);
		int unsigned v;
		case (which)
			REG_PLANE_WIDTH:
				v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 16);
			REG_PLANE_HEIGHT:
				v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 8);
			default: begin
				v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
				// upper data bits are don't-care for the 4-bit registers
				v = v | ($urandom_range(0, 127) << WIN_CFG_BITS);
			end
		endcase
		return v;
	endfunction

	// leaves cfg_we high; the caller drops it after the last write
	task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(value);
		@(posedge clk);
		pooler.write_reg(idx, CFG_DATA_BITS'(value));
	endtask

	task automatic program_all(input int unsigned pw, ph, ww, wh, sx, sy);
		cfg_write(REG_PLANE_WIDTH, pw);
		cfg_write(REG_PLANE_HEIGHT, ph);
		cfg_write(REG_WINDOW_WIDTH, ww);
		cfg_write(REG_WINDOW_HEIGHT, wh);
		cfg_write(REG_STRIDE_X, sx);
		cfg_write(REG_STRIDE_Y, sy);
		cfg_we <= 1'b0;
		n_configs++;
	endtask

	task automatic send(input logic signed [SAMPLE_W-1:0] s);
		int gap;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			gap = idle_len();
			if ($urandom_range(0, 59) == 0)
				send_calm = $urandom_range(20, 150);
		end
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid  <= 1'b1;
		samples_ch.sample <= s;
		do @(posedge clk); while (!samples_ch.ready);
		pooler.take_sample(s);
		n_sent++;
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (pooler.pooled_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (pooler.pooled_due.size() != 0) begin
			report($sformatf("%0d pooled values never arrived", pooler.pooled_due.size()));
			pooler.pooled_due.delete();
		end
		// samples that close no window may still be in the pipe
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic feed(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 199) == 0) begin
				samples_ch.valid <= 1'b0;
				wait_drained();
			end
			send(rand_sample());
		end
		samples_ch.valid <= 1'b0;
		wait_drained();
	endtask

	// result side: random backpressure, checks every accepted beat
	initial begin
		int stall, calm;
		logic rdy;
		pool_beat_t got;
		string msg;
		stall = 0;
		calm  = 0;
		pool_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pool_ch.valid && pool_ch.ready) begin
				got.value = pool_ch.pooled_value;
				got.eor   = pool_ch.end_of_row;
				got.eof   = pool_ch.end_of_frame;
				msg = pooler.match_pooled(got);
				if (msg != "")
					report(msg);
			end
			if (calm > 0) begin
				calm--;
				rdy = 1'b1;
			end else if (stall > 0) begin
				stall--;
				rdy = 1'b0;
			end else begin
				stall = idle_len();
				rdy = (stall == 0);
				if (stall > 0)
					stall--;
				if ($urandom_range(0, 39) == 0)
					calm = $urandom_range(20, 150);
			end
			pool_ch.ready <= rdy;
		end
	end

	initial begin
		int base_sent, n, area;
		reg_index_t which;
		bit first;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_PLANE_WIDTH;
		cfg_data          <= '0;
		samples_ch.valid  <= 1'b0;
		samples_ch.sample <= '0;
		pooler = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: 64 wide, 2x2 windows, stride 2
		feed(2 * 64 + 6);

		// every size register at zero behaves as one: each sample ends row and plane
		program_all(0, 0, 0, 0, 0, 0);
		send(16'sh8000);
		send(16'sh7FFF);
		send(16'sh0000);
		samples_ch.valid <= 1'b0;
		wait_drained();

		// overlapping 2x2 windows with extreme values
		program_all(3, 2, 2, 2, 1, 1);
		send(16'sh7FFF);
		send(16'sh8000);
		send(-16'sd1);
		send(16'sh8000);
		send(16'sh0000);
		send(16'sd1);
		samples_ch.valid <= 1'b0;
		wait_drained();

		// window wider than the plane: nothing comes out
		program_all(2, 2, 3, 2, 1, 1);
		for (int k = 0; k < 4; k++)
			send(rand_sample());
		samples_ch.valid <= 1'b0;
		wait_drained();

		// window size 15 clamps to 8, stride 15 used as given
		program_all(9, 1, 15, 1, 15, 15);
		for (int k = 0; k < 9; k++)
			send(SAMPLE_W'(k * 3000 - 12000));
		samples_ch.valid <= 1'b0;
		wait_drained();

		// oversized plane dimensions: the start of a long row, then of a tall column
		program_all(11'h7FF, 1, 8, 1, 15, 1);
		feed(48);
		program_all(1, 11'h7FF, 1, 8, 1, 15);
		feed(48);

		base_sent = n_sent;
		first     = 1'b1;
		while (n_sent - base_sent < RANDOM_ITEMS) begin
			case (first ? 3 : $urandom_range(0, 9))
				0: begin
					cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
						$urandom_range(0, (1 << CFG_DATA_BITS) - 1));
					cfg_we <= 1'b0;
				end
				1, 2: begin
					which = reg_index_t'($urandom_range(REG_PLANE_WIDTH, REG_STRIDE_Y));
					cfg_write(which, rand_reg_value(which));
					cfg_we <= 1'b0;
					n_configs++;
				end
				default:
					program_all(rand_reg_value(REG_PLANE_WIDTH), rand_reg_value(REG_PLANE_HEIGHT),
						rand_reg_value(REG_WINDOW_WIDTH), rand_reg_value(REG_WINDOW_HEIGHT),
						rand_reg_value(REG_STRIDE_X), rand_reg_value(REG_STRIDE_Y));
			endcase
			first = 1'b0;
			area = pooler.fit(pooler.plane_w, MAXPW) * pooler.fit(pooler.plane_h, MAXPW);
			n = $urandom_range(1, 2 * area + 2);
			if (n > PLANE_FEED)
				n = PLANE_FEED;
			feed(n);
		end

		$display("Covered %0d register settings and %0d samples, including zero, clamped",
			n_configs, n_sent);
		$display("and oversized sizes; %0d pooled values checked, %0d row ends, %0d plane ends",
			pooler.n_pooled, pooler.n_row_ends, pooler.n_plane_ends);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
